// ===== hdl/sha256_hash_engine_defines.svh =====
// Assertion macros used by the SHA-256 engine.
`ifndef SHA256_HASH_ENGINE_DEFINES_SVH
`define SHA256_HASH_ENGINE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMP(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

// ===== hdl/sha_pkg.sv =====
// ---------------------------------------------------------------------------
// sha_pkg
// Types, constants and round functions of the SHA-256 engine.
// ---------------------------------------------------------------------------
package sha_pkg;
  typedef logic [31:0] word_t;
  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_PAD, ST_EMIT
  } state_t;
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam word_t INIT_VALUE [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage

// ===== hdl/sha_round.sv =====
// ---------------------------------------------------------------------------
// sha_round
// Shared round unit: one compression round a cycle on a supplied schedule word.
// ---------------------------------------------------------------------------
module sha_round import sha_pkg::*; (
  input  word_t       v_in [8],
  input  word_t       w_in,
  input  logic [5:0]  rnd,
  output word_t       v_out [8]
);
  word_t e, a, t1, t2;
  always_comb begin
    e  = v_in[4];
    a  = v_in[0];
    t1 = v_in[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
         ((e & v_in[5]) ^ (~e & v_in[6])) + ROUND_K[rnd] + w_in;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
         ((a & v_in[1]) ^ (a & v_in[2]) ^ (v_in[1] & v_in[2]));
    v_out[7] = v_in[6];
    v_out[6] = v_in[5];
    v_out[5] = v_in[4];
    v_out[4] = v_in[3] + t1;
    v_out[3] = v_in[2];
    v_out[2] = v_in[1];
    v_out[1] = v_in[0];
    v_out[0] = t1 + t2;
  end
endmodule

// ===== hdl/sha256_hash_engine.sv =====
// SHA-256 engine. Bytes are taken only in idle; the 64th byte of a block holds
// the input through the round and fold states. Finish writes the 0x80 marker,
// pads the rest of the block and compresses it, then pads and compresses one
// more block when the marker lands at byte 56 or later; then one beat per
// digest byte. The round unit runs one round per cycle. Synchronous active-high reset
// loads the initial hash value, clears the bit count and sets digest_size to 32.
// ---------------------------------------------------------------------------
// sha256_hash_engine
// Byte-serial SHA-256 with one shared round unit under a small sequencer.
// ---------------------------------------------------------------------------
`include "sha256_hash_engine_defines.svh"
module sha256_hash_engine import sha_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tuser,   // [0] kind
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] digest_byte
  output logic       m_tlast,   // last
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data   // digest_size
);
  state_t state, state_next;
  word_t  hash [8];
  word_t  v [8];
  word_t  v_rnd [8];
  word_t  sched [16];         // holds block words, then rolling schedule
  logic [63:0] bit_count;
  logic [5:0]  digest_size;
  logic [5:0]  rnd;
  logic [5:0]  pad_pos;       // next byte position during padding
  logic        final_blk;     // block under compression ends the message
  logic        pad_run;       // finish seen, padding still in progress
  logic [4:0]  emit_idx;
  logic [5:0]  emit_n;
  word_t  w_cur, x, y;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);

  // Schedule word for this round: loaded word or the recurrence.
  always_comb begin
    x = sched[rnd[3:0] + 4'd1];
    y = sched[rnd[3:0] + 4'd14];
    if (rnd < 6'd16) begin
      w_cur = sched[rnd[3:0]];
    end else begin
      w_cur = sched[rnd[3:0]] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) +
              (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10)) + sched[rnd[3:0] + 4'd9];
    end
  end

  sha_round u_round (.v_in(v), .w_in(w_cur), .rnd(rnd), .v_out(v_rnd));

  // Write one byte big-endian into the word buffer.
  function automatic word_t put_byte(word_t w, logic [1:0] pos, logic [7:0] b);
    word_t r;
    r = w;
    r[{~pos, 3'b000} +: 8] = b;
    return r;
  endfunction

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) begin
        // A byte or a marker landing in the last slot fills the block.
        if (bit_count[8:3] == 6'd63) state_next = ST_ROUND;
        else if (s_tuser == KIND_FINISH) state_next = ST_PAD;
      end
      ST_PAD:   if (pad_pos == 6'd63) state_next = ST_ROUND;
      ST_ROUND: if (rnd == 6'd63) state_next = ST_FOLD;
      ST_FOLD:  state_next = final_blk ? ST_EMIT : (pad_run ? ST_PAD : ST_IDLE);
      ST_EMIT:  if (m_tready && {1'b0, emit_idx} + 6'd1 == emit_n) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hash <= INIT_VALUE;
      bit_count <= '0;
      digest_size <= 6'd32;
      rnd <= '0;
      pad_pos <= '0;
      final_blk <= 1'b0;
      pad_run <= 1'b0;
      emit_idx <= '0;
      emit_n <= 6'd1;
    end else begin
      state <= state_next;
      if (cfg_valid) digest_size <= cfg_data;
      case (state)
        ST_IDLE: if (s_tvalid) begin
          rnd <= '0;
          v <= hash;
          if (s_tuser == KIND_DATA) begin
            sched[bit_count[8:5]] <= put_byte(sched[bit_count[8:5]], bit_count[4:3],
                                              s_tdata);
            bit_count <= bit_count + 64'd8;
            final_blk <= 1'b0;
            pad_run <= 1'b0;
            pad_pos <= '0;
          end else begin
            sched[bit_count[8:5]] <= put_byte(sched[bit_count[8:5]], bit_count[4:3],
                                              8'h80);
            pad_pos <= bit_count[8:3] + 6'd1;
            pad_run <= 1'b1;
            // Length fits in this block only if 0x80 landed before byte 56.
            final_blk <= (bit_count[8:3] < 6'd56);
          end
        end
        ST_PAD: begin
          if (pad_pos >= 6'd56 && final_blk)
            sched[pad_pos[5:2]] <= put_byte(sched[pad_pos[5:2]], pad_pos[1:0],
                                            bit_count[{~pad_pos[2:0], 3'b000} +: 8]);
          else
            sched[pad_pos[5:2]] <= put_byte(sched[pad_pos[5:2]], pad_pos[1:0], 8'h00);
          pad_pos <= pad_pos + 6'd1;
          if (pad_pos == 6'd63) begin
            rnd <= '0;
            v <= hash;
          end
        end
        ST_ROUND: begin
          v <= v_rnd;
          sched[rnd[3:0]] <= w_cur;
          rnd <= rnd + 6'd1;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
          if (!final_blk && pad_run) begin
            // Overflow block done; pad a fresh block ending in the length.
            final_blk <= 1'b1;
            pad_pos <= '0;
          end
          emit_idx <= '0;
          emit_n <= (digest_size == 6'd0) ? 6'd1 :
                    (digest_size > 6'd32) ? 6'd32 : digest_size;
        end
        ST_EMIT: if (m_tready) begin
          emit_idx <= emit_idx + 5'd1;
          if ({1'b0, emit_idx} + 6'd1 == emit_n) begin
            hash <= INIT_VALUE;
            bit_count <= '0;
            final_blk <= 1'b0;
            pad_run <= 1'b0;
            pad_pos <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tvalid = (state == ST_EMIT);
  assign m_tdata  = hash[emit_idx[4:2]][{~emit_idx[1:0], 3'b000} +: 8];
  assign m_tlast  = ({1'b0, emit_idx} + 6'd1 == emit_n);

  `SHA_ASSERT_IMP(a_ready_idle, s_tready, state == ST_IDLE, "ready outside idle")
  `SHA_ASSERT_NXT(a_round_adv, state == ST_ROUND && rnd != 6'd63,
                  state == ST_ROUND, "round loop broke early")
  `SHA_ASSERT_NXT(a_last_end, m_tvalid && m_tready && m_tlast, state == ST_IDLE,
                  "emit did not end on last")
endmodule
